[src/m4au_pkg.sv]
`default_nettype none

package m4au_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = $clog2(DIM);
    localparam int N_ELEM    = 4;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 66;
    localparam int NQ_W      = DATA_W + FRAC_BITS;
    localparam int STEP_W    = 3;

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        ACT_LOAD_ACC  = 4'd0,
        ACT_LOAD_OP   = 4'd1,
        ACT_ADD       = 4'd2,
        ACT_SUB       = 4'd3,
        ACT_MUL       = 4'd4,
        ACT_TRANSPOSE = 4'd5,
        ACT_SCALE     = 4'd6,
        ACT_DIVIDE    = 4'd7,
        ACT_ZERO      = 4'd8,
        ACT_IDENTITY  = 4'd9,
        ACT_READ      = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE,
        S_READ
    } state_t;

    typedef struct packed {
        logic [3:0]         action;
        logic [1:0]         row;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic signed [31:0] out_elem_0;
        logic signed [31:0] out_elem_1;
        logic signed [31:0] out_elem_2;
        logic signed [31:0] out_elem_3;
        logic               last;
        logic [1:0]         status;
    } rsp_item_t;

    typedef struct packed {
        logic       clr;
        logic       mul_en;
        logic       div_start;
        logic [3:0] action;
    } lane_ctrl_t;

    typedef struct packed {
        logic       sat_clr;
        logic       div0;
        logic       row_wr;
        logic       emit;
        logic       is_read;
        logic [1:0] row;
        logic       last;
    } merge_ctrl_t;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } sat_res_t;

    // Clamp a wide signed value to the 32-bit range and flag the clamp.
    function automatic sat_res_t sat32(input logic signed [SUM_W-1:0] v);
        sat_res_t r;
        r.sat = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > SAT_HI) begin
            r.sat = 1'b1;
            r.val = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            r.sat = 1'b1;
            r.val = SAT_LO[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/matrix4_arithmetic_unit_core.sv]
`default_nettype none

// Channel  | Ports                       | Payload
// ---------+-----------------------------+--------------------------------
// request  | req_valid, req_stall, req   | action, row, elem_0..elem_3
// response | rsp_valid, rsp_stall, rsp   | out_row, out_elem_0..3, last, status
//
// One item is worked at a time. Loads, transpose, zero and identity finish in
// the accepting cycle; add and subtract write the rows in turn, scale passes each
// row through the lane multiplier and rounding, multiply sums the four products
// per element over k, and divide uses the one-bit-per-cycle divider in each lane.
// Reset clears both matrices. A stalled response holds its register while the
// block finishes the next item's work, then waits before it emits.
module matrix4_arithmetic_unit_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_stall,
    input  m4au_pkg::req_item_t     req,
    output logic                    rsp_valid,
    input  wire                     rsp_stall,
    output m4au_pkg::rsp_item_t     rsp
);
    import m4au_pkg::*;

    // Both matrices live in flip-flops so reset clears them at once.
    logic signed [31:0] acc_reg [DIM][DIM];
    logic signed [31:0] op_reg  [DIM][DIM];

    state_t             state_reg, state_next;
    logic [3:0]         act_reg, act_next;
    logic signed [31:0] scalar_reg, scalar_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    logic               accept;
    logic               free;
    logic               row_wr;
    logic               clr, mul_en, div_start;
    logic [ROW_W-1:0]   k;
    logic signed [31:0] req_elem [N_ELEM];
    logic signed [31:0] lane_a   [DIM];
    logic signed [31:0] lane_b   [DIM];
    logic signed [31:0] lane_res [DIM];
    logic [DIM-1:0]     lane_sat;
    logic [DIM-1:0]     lane_busy;
    logic signed [31:0] row_data [DIM];
    lane_ctrl_t         lctrl;
    merge_ctrl_t        mctrl;

    assign req_elem[0] = req.elem_0;
    assign req_elem[1] = req.elem_1;
    assign req_elem[2] = req.elem_2;
    assign req_elem[3] = req.elem_3;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign k         = step_reg[ROW_W-1:0];

    // Sequencer: picks the row, the multiply step and the write-back cycle.
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        scalar_next = scalar_reg;
        row_next    = row_reg;
        step_next   = step_reg;
        row_wr      = 1'b0;
        clr         = 1'b0;
        mul_en      = 1'b0;
        div_start   = 1'b0;
        mctrl       = '0;
        mctrl.row   = 2'(row_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next     = req.action;
                    scalar_next  = req.elem_0;
                    row_next     = '0;
                    step_next    = '0;
                    mctrl.sat_clr = 1'b1;
                    unique case (req.action)
                        ACT_ADD, ACT_SUB, ACT_MUL, ACT_SCALE: state_next = S_RUN;
                        ACT_DIVIDE:
                        begin
                            if (req.elem_0 == '0)
                            begin
                                mctrl.div0 = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_RUN;
                        end
                        ACT_READ: state_next = S_READ;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_RUN:
            begin
                unique case (act_reg)
                    ACT_MUL:
                    begin
                        mul_en = (step_reg < STEP_W'(DIM));
                        clr    = (step_reg == '0);
                        row_wr = (step_reg == STEP_W'(DIM + 1));
                    end
                    ACT_SCALE:
                    begin
                        mul_en = (step_reg == '0);
                        clr    = (step_reg == '0);
                        row_wr = (step_reg == STEP_W'(2));
                    end
                    ACT_DIVIDE:
                    begin
                        div_start = (step_reg == '0);
                        row_wr    = (step_reg != '0) && !lane_busy[0];
                    end
                    default: row_wr = 1'b1;
                endcase
                if (row_wr)
                begin
                    step_next = '0;
                    row_next  = row_reg + 1'b1;
                    if (row_reg == ROW_W'(DIM - 1))
                        state_next = S_DONE;
                end
                else if (!(act_reg == ACT_DIVIDE && step_reg != '0))
                begin
                    step_next = step_reg + 1'b1;
                end
                mctrl.row_wr = row_wr;
            end
            S_DONE:
            begin
                if (free)
                begin
                    mctrl.emit = 1'b1;
                    mctrl.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                mctrl.is_read = 1'b1;
                if (free)
                begin
                    mctrl.emit = 1'b1;
                    mctrl.last = (row_reg == ROW_W'(DIM - 1));
                    row_next   = row_reg + 1'b1;
                    if (row_reg == ROW_W'(DIM - 1))
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= '0;
            scalar_reg <= '0;
            row_reg    <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            scalar_reg <= scalar_next;
            row_reg    <= row_next;
            step_reg   <= step_next;
        end
    end

    // Matrix storage: load, transpose, zero and identity at accept, lane results per row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < DIM; r++)
                for (int c = 0; c < DIM; c++)
                begin
                    acc_reg[r][c] <= '0;
                    op_reg[r][c]  <= '0;
                end
        end
        else
        begin
            if (accept)
            begin
                unique case (req.action)
                    ACT_LOAD_ACC:
                    begin
                        if (req.row < DIM)
                            for (int c = 0; c < DIM; c++)
                                acc_reg[req.row[ROW_W-1:0]][c] <= req_elem[c];
                    end
                    ACT_LOAD_OP:
                    begin
                        if (req.row < DIM)
                            for (int c = 0; c < DIM; c++)
                                op_reg[req.row[ROW_W-1:0]][c] <= req_elem[c];
                    end
                    ACT_TRANSPOSE:
                    begin
                        for (int r = 0; r < DIM; r++)
                            for (int c = 0; c < DIM; c++)
                                acc_reg[r][c] <= acc_reg[c][r];
                    end
                    ACT_ZERO, ACT_IDENTITY:
                    begin
                        for (int r = 0; r < DIM; r++)
                            for (int c = 0; c < DIM; c++)
                                acc_reg[r][c] <= (req.action == ACT_IDENTITY && r == c)
                                                 ? ONE_FIX : '0;
                    end
                    default: ;
                endcase
            end
            if (row_wr)
            begin
                for (int c = 0; c < DIM; c++)
                    acc_reg[row_reg][c] <= lane_res[c];
            end
        end
    end

    assign lctrl.clr       = clr;
    assign lctrl.mul_en    = mul_en;
    assign lctrl.div_start = div_start;
    assign lctrl.action    = act_reg;

    // One lane per column. Multiply walks k over the accumulator row.
    for (genvar c = 0; c < DIM; c++)
    begin : g_lane
        always_comb
        begin
            if (act_reg == ACT_MUL)
            begin
                lane_a[c] = acc_reg[row_reg][k];
                lane_b[c] = op_reg[k][c];
            end
            else if (act_reg == ACT_SCALE || act_reg == ACT_DIVIDE)
            begin
                lane_a[c] = acc_reg[row_reg][c];
                lane_b[c] = scalar_reg;
            end
            else
            begin
                lane_a[c] = acc_reg[row_reg][c];
                lane_b[c] = op_reg[row_reg][c];
            end
        end

        assign row_data[c] = acc_reg[row_reg][c];

        m4au_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lctrl),
            .a        (lane_a[c]),
            .b        (lane_b[c]),
            .res      (lane_res[c]),
            .sat      (lane_sat[c]),
            .div_busy (lane_busy[c])
        );
    end

    m4au_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mctrl),
        .lane_sat  (lane_sat),
        .row_data  (row_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .free      (free)
    );

endmodule

`default_nettype wire

[src/m4au_lane.sv]
`default_nettype none

module m4au_lane (
    input  wire                       clk,
    input  wire                       rst_n,
    input  m4au_pkg::lane_ctrl_t      ctrl,
    input  wire logic signed [31:0]   a,
    input  wire logic signed [31:0]   b,
    output logic signed [31:0]        res,
    output logic                      sat,
    output logic                      div_busy
);
    import m4au_pkg::*;

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    logic signed [63:0]      prod_next;
    logic signed [63:0]      prod_reg;
    logic                    pv_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] rnd;

    logic                    busy_reg;
    logic [5:0]              cnt_reg;
    logic [NQ_W-1:0]         nq_reg;
    logic [DATA_W-1:0]       rem_reg;
    logic [DATA_W-1:0]       d_reg;
    logic                    neg_reg;

    logic [DATA_W-1:0]       abs_a;
    logic [DATA_W-1:0]       abs_b;
    logic [NQ_W-1:0]         n0;
    logic [DATA_W:0]         rem_sh;
    logic                    ge;
    logic signed [NQ_W:0]    qs;
    logic signed [NQ_W:0]    dv;
    logic signed [DATA_W:0]  addsub;
    sat_res_t                sr;

    assign prod_next = a * b;

    // Multiply pipeline: product register, then exact accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.clr)
        begin
            sum_reg <= '0;
        end
        else if (pv_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
    end

    assign rnd = (sum_reg + HALF) >>> FRAC_BITS;

    // Restoring divider, one quotient bit per cycle.
    assign abs_a  = a[31] ? (~a + 1'b1) : a;
    assign abs_b  = b[31] ? (~b + 1'b1) : b;
    assign n0     = {abs_a, {FRAC_BITS{1'b0}}} + NQ_W'(abs_b >> 1);
    assign rem_sh = {rem_reg, nq_reg[NQ_W-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (ctrl.div_start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && cnt_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            nq_reg  <= n0;
            rem_reg <= '0;
            d_reg   <= abs_b;
            neg_reg <= a[31] ^ b[31];
            cnt_reg <= 6'(NQ_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DATA_W'(rem_sh - {1'b0, d_reg}) : rem_sh[DATA_W-1:0];
            nq_reg  <= {nq_reg[NQ_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign div_busy = busy_reg;
    assign qs       = {1'b0, nq_reg};
    assign dv       = neg_reg ? -qs : qs;
    assign addsub   = (ctrl.action == ACT_SUB) ? a - b : a + b;

    always_comb
    begin
        case (ctrl.action)
            ACT_ADD, ACT_SUB: sr = sat32(SUM_W'(addsub));
            ACT_DIVIDE:       sr = sat32(SUM_W'(dv));
            default:          sr = sat32(rnd);
        endcase
    end

    assign res = sr.val;
    assign sat = sr.sat;

endmodule

`default_nettype wire

[src/m4au_merge.sv]
`default_nettype none

module m4au_merge (
    input  wire                        clk,
    input  wire                        rst_n,
    input  m4au_pkg::merge_ctrl_t      ctrl,
    input  wire logic [m4au_pkg::DIM-1:0] lane_sat,
    input  wire logic signed [31:0]    row_data [m4au_pkg::DIM],
    input  wire                        rsp_stall,
    output logic                       rsp_valid,
    output m4au_pkg::rsp_item_t        rsp,
    output logic                       free
);
    import m4au_pkg::*;

    logic               sat_reg;
    logic               div0_reg;
    logic               valid_reg;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;
    logic signed [31:0] el [N_ELEM];

    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        for (int j = 0; j < N_ELEM; j++)
        begin
            el[j] = (ctrl.is_read && j < DIM) ? row_data[ROW_W'(j)] : '0;
        end
        rsp_next.out_row    = ctrl.is_read ? ctrl.row : 2'd0;
        rsp_next.out_elem_0 = el[0];
        rsp_next.out_elem_1 = el[1];
        rsp_next.out_elem_2 = el[2];
        rsp_next.out_elem_3 = el[3];
        rsp_next.last       = ctrl.last;
        if (ctrl.is_read)
            rsp_next.status = ST_OK;
        else if (div0_reg)
            rsp_next.status = ST_DIV0;
        else if (sat_reg)
            rsp_next.status = ST_SAT;
        else
            rsp_next.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= 1'b0;
            div0_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.sat_clr)
            begin
                sat_reg  <= 1'b0;
                div0_reg <= ctrl.div0;
            end
            else if (ctrl.row_wr)
            begin
                sat_reg <= sat_reg | (|lane_sat);
            end
            if (ctrl.emit)
                valid_reg <= 1'b1;
            else if (!rsp_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> free) else $error("item emitted while output held");
    a_not_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !rsp_reg.last) |-> (rsp_reg.status == ST_OK))
        else $error("read row carries error status");
    a_clr_vs_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.sat_clr && ctrl.row_wr)) else $error("flag clear during row write");
`endif

endmodule

`default_nettype wire
